>>> rtl/rcws_pkg.sv
// Package with shared types, constants and the divider step for the wheel speed core.
`default_nettype none
package rcws_pkg;

    localparam int unsigned RANGE_W   = 10;
    localparam int unsigned DIVISOR_W = 8;
    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned CMD_W     = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned SPEED_W   = 12;
    localparam int unsigned LEVEL_W   = 4;
    localparam int unsigned DIVIDEND_W = 14;
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [RANGE_W-1:0]   SPEED_RANGE_RST = 10'd255;
    localparam logic [DIVISOR_W-1:0] TURN_DIV_RST    = 8'd2;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 16'd1000;

    localparam logic [DIVISOR_W-1:0] LEVEL_DIV  = 8'd12;
    localparam logic [LEVEL_W-1:0]   LEVEL_MAX  = 4'd10;
    localparam logic [RANGE_W-1:0]   FWD_MAX    = 10'd937;

    localparam logic [2:0] TURN_PAIRS = 3'd5;
    localparam logic [2:0] FWD_PAIRS  = 3'd7;

    localparam logic [1:0] REG_SPEED_RANGE = 2'd0;
    localparam logic [1:0] REG_TURN_DIV    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT     = 2'd2;

    localparam logic [CMD_W-1:0] CH_NONE  = 8'h00;
    localparam logic [CMD_W-1:0] CH_STOP  = 8'h53;
    localparam logic [CMD_W-1:0] CH_LVMAX = 8'h71;
    localparam logic [CMD_W-1:0] CH_FWD   = 8'h46;
    localparam logic [CMD_W-1:0] CH_BACK  = 8'h42;
    localparam logic [CMD_W-1:0] CH_RIGHT = 8'h52;
    localparam logic [CMD_W-1:0] CH_LEFT  = 8'h4C;
    localparam logic [CMD_W-1:0] CH_FWD_L = 8'h49;
    localparam logic [CMD_W-1:0] CH_FWD_R = 8'h47;
    localparam logic [CMD_W-1:0] CH_BK_L  = 8'h4A;
    localparam logic [CMD_W-1:0] CH_BK_R  = 8'h48;
    localparam logic [CMD_W-1:0] CH_TRI_ON  = 8'h58;
    localparam logic [CMD_W-1:0] CH_TRI_OFF = 8'h78;
    localparam logic [CMD_W-1:0] CH_DIGIT0  = 8'h30;
    localparam logic [CMD_W-1:0] CH_DIGIT9  = 8'h39;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DIV_TURN = 5'b00010,
        S_APPLY    = 5'b00100,
        S_DIV_FWD  = 5'b01000,
        S_OUT      = 5'b10000
    } state_t;

    typedef struct packed {
        logic [DIVISOR_W-1:0] rem;
        logic                 qbit;
    } div_step_t;

    // One restoring division step: shift in a dividend bit and try to subtract.
    function automatic div_step_t div_step(input logic [DIVISOR_W-1:0] rem,
                                           input logic                 in_bit,
                                           input logic [DIVISOR_W-1:0] divisor);
        logic [DIVISOR_W:0] shifted;
        logic [DIVISOR_W:0] diff;
        div_step_t          res;
        shifted = {rem, in_bit};
        diff    = shifted - {1'b0, divisor};
        if (shifted >= {1'b0, divisor}) begin
            res.rem  = diff[DIVISOR_W-1:0];
            res.qbit = 1'b1;
        end
        else begin
            res.rem  = shifted[DIVISOR_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/rc_command_to_wheel_speed_core.sv
// Top level of the remote-control command to wheel speed decoder.
// Each transaction takes a command byte and a millisecond time and yields one result
// transaction with both wheel speeds and the triangle flag. The block works on one
// transaction at a time: in_stall stays high from acceptance until the result has been
// taken. A command byte passes through the turn division, a decode state, the forward
// speed division and a result state that holds while out_stall is high, then returns to
// idle; a zero byte skips the forward speed division. The single shared restoring divider
// retires two quotient bits per cycle and serves both the turn speed and the forward speed
// divisions.
`default_nettype none
module rc_command_to_wheel_speed_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [rcws_pkg::CMD_W-1:0]            cmd_byte,
    input  wire logic [rcws_pkg::TIME_W-1:0]           now_ms,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [rcws_pkg::SPEED_W-1:0]        right_speed,
    output logic signed [rcws_pkg::SPEED_W-1:0]        left_speed,
    output logic                                       triangle_mode,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [rcws_pkg::PADDR_W-1:0]          paddr,
    input  wire logic [rcws_pkg::PDATA_W-1:0]          pwdata,
    output logic [rcws_pkg::PDATA_W-1:0]               prdata,
    output logic                                       pready
);
    import rcws_pkg::*;

    state_t                state_reg, state_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [DIVISOR_W-1:0]  d_reg, d_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic                  tri_reg, tri_next;
    logic signed [SPEED_W-1:0] right_reg, right_next;
    logic signed [SPEED_W-1:0] left_reg, left_next;
    logic [RANGE_W-1:0]    fwd_reg, fwd_next;
    logic [TIME_W-1:0]     last_rx_reg, last_rx_next;
    logic [RANGE_W-1:0]    range_reg;
    logic [DIVISOR_W-1:0]  tdiv_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;

    div_step_t             step_a, step_b;
    logic [DIVIDEND_W-1:0] q_step;
    logic signed [SPEED_W-1:0] f_s, t_s;
    logic [TIME_W-1:0]     elapsed;
    logic [DIVIDEND_W-1:0] product;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign right_speed   = right_reg;
    assign left_speed    = left_reg;
    assign triangle_mode = tri_reg;

    always_comb
    begin
        case (paddr[3:2])
            REG_SPEED_RANGE: prdata = {{(PDATA_W-RANGE_W){1'b0}}, range_reg};
            REG_TURN_DIV:    prdata = {{(PDATA_W-DIVISOR_W){1'b0}}, tdiv_reg};
            REG_TIMEOUT:     prdata = {{(PDATA_W-TIMEOUT_W){1'b0}}, timeout_reg};
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        step_a  = div_step(rem_reg, q_reg[DIVIDEND_W-1], d_reg);
        step_b  = div_step(step_a.rem, q_reg[DIVIDEND_W-2], d_reg);
        q_step  = {q_reg[DIVIDEND_W-3:0], step_a.qbit, step_b.qbit};
        f_s     = signed'({2'b00, fwd_reg});
        t_s     = signed'({2'b00, q_reg[RANGE_W-1:0]});
        elapsed = now_reg - last_rx_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        d_next       = d_reg;
        cmd_next     = cmd_reg;
        now_next     = now_reg;
        level_next   = level_reg;
        tri_next     = tri_reg;
        right_next   = right_reg;
        left_next    = left_reg;
        fwd_next     = fwd_reg;
        last_rx_next = last_rx_reg;
        product      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd_byte;
                    now_next   = now_ms;
                    rem_next   = '0;
                    q_next     = {fwd_reg, {(DIVIDEND_W-RANGE_W){1'b0}}};
                    d_next     = (tdiv_reg == '0) ? {{(DIVISOR_W-1){1'b0}}, 1'b1} : tdiv_reg;
                    cnt_next   = TURN_PAIRS;
                    state_next = S_DIV_TURN;
                end
            end
            S_DIV_TURN:
            begin
                rem_next = step_b.rem;
                q_next   = q_step;
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd1)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (cmd_reg == CH_NONE)
                begin
                    if (elapsed > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_reg})
                    begin
                        right_next = '0;
                        left_next  = '0;
                        fwd_next   = '0;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    last_rx_next = now_reg;
                    case (cmd_reg)
                        CH_STOP:
                        begin
                            right_next = '0;
                            left_next  = '0;
                        end
                        CH_LVMAX: level_next = LEVEL_MAX;
                        CH_FWD:
                        begin
                            right_next = f_s;
                            left_next  = f_s;
                        end
                        CH_BACK:
                        begin
                            right_next = -f_s;
                            left_next  = -f_s;
                        end
                        CH_RIGHT:
                        begin
                            right_next = -t_s;
                            left_next  = t_s;
                        end
                        CH_LEFT:
                        begin
                            right_next = t_s;
                            left_next  = -t_s;
                        end
                        CH_FWD_L:
                        begin
                            right_next = f_s - t_s;
                            left_next  = f_s + t_s;
                        end
                        CH_FWD_R:
                        begin
                            right_next = f_s + t_s;
                            left_next  = f_s - t_s;
                        end
                        CH_BK_L:
                        begin
                            right_next = t_s - f_s;
                            left_next  = -f_s - t_s;
                        end
                        CH_BK_R:
                        begin
                            right_next = -f_s - t_s;
                            left_next  = t_s - f_s;
                        end
                        CH_TRI_ON:  tri_next = 1'b1;
                        CH_TRI_OFF: tri_next = 1'b0;
                        default:
                        begin
                            if (cmd_reg >= CH_DIGIT0 && cmd_reg <= CH_DIGIT9)
                            begin
                                level_next = LEVEL_W'(cmd_reg - CH_DIGIT0);
                            end
                        end
                    endcase
                    product    = DIVIDEND_W'(range_reg * (level_next + 4'd1));
                    rem_next   = '0;
                    q_next     = product;
                    d_next     = LEVEL_DIV;
                    cnt_next   = FWD_PAIRS;
                    state_next = S_DIV_FWD;
                end
            end
            S_DIV_FWD:
            begin
                rem_next = step_b.rem;
                q_next   = q_step;
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd1)
                begin
                    fwd_next   = q_step[RANGE_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            q_reg       <= '0;
            d_reg       <= '0;
            cmd_reg     <= '0;
            now_reg     <= '0;
            level_reg   <= '0;
            tri_reg     <= 1'b0;
            right_reg   <= '0;
            left_reg    <= '0;
            fwd_reg     <= '0;
            last_rx_reg <= '0;
            range_reg   <= SPEED_RANGE_RST;
            tdiv_reg    <= TURN_DIV_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            q_reg       <= q_next;
            d_reg       <= d_next;
            cmd_reg     <= cmd_next;
            now_reg     <= now_next;
            level_reg   <= level_next;
            tri_reg     <= tri_next;
            right_reg   <= right_next;
            left_reg    <= left_next;
            fwd_reg     <= fwd_next;
            last_rx_reg <= last_rx_next;
            if (cfg_write)
            begin
                case (paddr[3:2])
                    REG_SPEED_RANGE: range_reg   <= pwdata[RANGE_W-1:0];
                    REG_TURN_DIV:    tdiv_reg    <= pwdata[DIVISOR_W-1:0];
                    REG_TIMEOUT:     timeout_reg <= pwdata[TIMEOUT_W-1:0];
                    default:         range_reg   <= range_reg;
                endcase
            end
        end
    end

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DIV_TURN))
        else $error("Accepted transaction did not start the turn division.");

    a_fwd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg <= FWD_MAX)
        else $error("Forward speed exceeds its maximum.");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_TURN || state_reg == S_DIV_FWD) |-> (d_reg != '0))
        else $error("Divider running with a zero divisor.");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_TURN || state_reg == S_DIV_FWD) |-> (rem_reg < d_reg))
        else $error("Divider remainder not below the divisor.");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(right_reg) && $stable(left_reg)))
        else $error("Stalled result changed.");

endmodule
`default_nettype wire

>>> dv/tb_rc_command_to_wheel_speed_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the remote-control command to wheel speed core.
module tb_rc_command_to_wheel_speed_core;
    import rcws_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] stamp;
    } cmd_txn_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] right_spd;
        logic signed [SPEED_W-1:0] left_spd;
        logic                      tri_on;
    } wheel_txn_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [CMD_W-1:0]          cmd_byte = '0;
    logic [TIME_W-1:0]         now_ms = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [SPEED_W-1:0] left_speed;
    logic                      triangle_mode;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    rc_command_to_wheel_speed_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd_byte      (cmd_byte),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .right_speed   (right_speed),
        .left_speed    (left_speed),
        .triangle_mode (triangle_mode),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cmd_txn_t   cmd_queue[$];
    wheel_txn_t expected_wheels[$];
    cmd_txn_t   drive_txn;
    logic       in_fire = 1'b0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         pushed_count = 0;
    int         accepted_count = 0;
    int         fail_count = 0;

    int unsigned       cfg_range = 255;
    int unsigned       cfg_div = 2;
    int unsigned       cfg_timeout = 1000;
    int                car_level = 0;
    logic              car_tri = 1'b0;
    int                car_right = 0;
    int                car_left = 0;
    int                car_fwd = 0;
    int                car_turn = 0;
    logic [TIME_W-1:0] car_last_rx = '0;

    logic [TIME_W-1:0] gen_clock = '0;
    logic [TIME_W-1:0] gen_last = '0;

    logic [CMD_W-1:0] drive_cmds [12] = '{CH_STOP, CH_FWD, CH_BACK, CH_RIGHT, CH_LEFT,
                                          CH_FWD_L, CH_FWD_R, CH_BK_L, CH_BK_R,
                                          CH_TRI_ON, CH_TRI_OFF, CH_LVMAX};

    function automatic wheel_txn_t predict_wheels(input logic [CMD_W-1:0]  c,
                                                  input logic [TIME_W-1:0] t);
        int                divisor;
        int                f;
        int                tn;
        logic [TIME_W-1:0] elapsed;
        wheel_txn_t        res;
        divisor  = (cfg_div == 0) ? 1 : int'(cfg_div);
        car_turn = car_fwd / divisor;
        f        = car_fwd;
        tn       = car_turn;
        if (c == CH_NONE)
        begin
            elapsed = t - car_last_rx;
            if (elapsed > cfg_timeout)
            begin
                car_right = 0;
                car_left  = 0;
                car_fwd   = 0;
            end
        end
        else
        begin
            car_last_rx = t;
            case (c)
                CH_STOP:    begin car_right = 0;       car_left = 0;       end
                CH_FWD:     begin car_right = f;       car_left = f;       end
                CH_BACK:    begin car_right = -f;      car_left = -f;      end
                CH_RIGHT:   begin car_right = -tn;     car_left = tn;      end
                CH_LEFT:    begin car_right = tn;      car_left = -tn;     end
                CH_FWD_L:   begin car_right = f - tn;  car_left = f + tn;  end
                CH_FWD_R:   begin car_right = f + tn;  car_left = f - tn;  end
                CH_BK_L:    begin car_right = -f + tn; car_left = -f - tn; end
                CH_BK_R:    begin car_right = -f - tn; car_left = -f + tn; end
                CH_LVMAX:   car_level = int'(LEVEL_MAX);
                CH_TRI_ON:  car_tri = 1'b1;
                CH_TRI_OFF: car_tri = 1'b0;
                default:
                begin
                    if (c >= CH_DIGIT0 && c <= CH_DIGIT9)
                        car_level = int'(c - CH_DIGIT0);
                end
            endcase
            car_fwd = int'((cfg_range * (car_level + 1)) / LEVEL_DIV);
        end
        res.right_spd = SPEED_W'(car_right);
        res.left_spd  = SPEED_W'(car_left);
        res.tri_on    = car_tri;
        return res;
    endfunction

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (rst_n && cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drive_txn = cmd_queue.pop_front();
                in_valid <= 1'b1;
                cmd_byte <= drive_txn.cmd;
                now_ms   <= drive_txn.stamp;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        wheel_txn_t want;
        in_fire <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            expected_wheels.push_back(predict_wheels(cmd_byte, now_ms));
            accepted_count++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_wheels.size() == 0)
            begin
                $error("result transaction with no expected result pending");
                fail_count++;
            end
            else
            begin
                want = expected_wheels.pop_front();
                if (right_speed !== want.right_spd)
                begin
                    $error("right_speed mismatch: expected %0d, actual %0d",
                           want.right_spd, right_speed);
                    fail_count++;
                end
                if (left_speed !== want.left_spd)
                begin
                    $error("left_speed mismatch: expected %0d, actual %0d",
                           want.left_spd, left_speed);
                    fail_count++;
                end
                if (triangle_mode !== want.tri_on)
                begin
                    $error("triangle_mode mismatch: expected %0d, actual %0d",
                           want.tri_on, triangle_mode);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_SPEED_RANGE: cfg_range = value & 32'h3FF;
            REG_TURN_DIV:    cfg_div = value & 32'hFF;
            REG_TIMEOUT:     cfg_timeout = value & 32'hFFFF;
            default:         ;
        endcase
    endtask

    task automatic set_config(input int unsigned range, input int unsigned div,
                              input int unsigned timeout);
        write_reg(REG_SPEED_RANGE, range);
        write_reg(REG_TURN_DIV, div);
        write_reg(REG_TIMEOUT, timeout);
    endtask

    task automatic push_cmd(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t);
        cmd_txn_t txn;
        txn.cmd   = c;
        txn.stamp = t;
        cmd_queue.push_back(txn);
        pushed_count++;
        gen_clock = t;
        if (c != CH_NONE)
            gen_last = t;
    endtask

    task automatic push_random(input int count);
        int                sel;
        logic [CMD_W-1:0]  c;
        logic [TIME_W-1:0] t;
        repeat (count)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
                t = gen_clock + $urandom_range(50);
            else if (sel < 70)
                t = gen_last + cfg_timeout + $urandom_range(2) - 1;
            else if (sel < 90)
                t = gen_clock + $urandom_range(2 * cfg_timeout + 100);
            else
                t = $urandom();
            sel = $urandom_range(99);
            if (sel < 35)
                c = CH_NONE;
            else if (sel < 70)
                c = drive_cmds[$urandom_range(11)];
            else if (sel < 85)
                c = CH_DIGIT0 + CMD_W'($urandom_range(9));
            else
                c = CMD_W'($urandom_range(255));
            push_cmd(c, t);
        end
    endtask

    task automatic drain;
        while (accepted_count != pushed_count || expected_wheels.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall, input int count);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        push_random(count);
        drain();
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        push_cmd(CH_NONE, 32'd500);
        push_cmd(CH_LVMAX, 32'd600);
        push_cmd(CH_FWD, 32'd610);
        push_cmd(CH_BACK, 32'd620);
        push_cmd(CH_RIGHT, 32'd630);
        push_cmd(CH_LEFT, 32'd640);
        push_cmd(CH_FWD_L, 32'd650);
        push_cmd(CH_FWD_R, 32'd660);
        push_cmd(CH_BK_L, 32'd670);
        push_cmd(CH_BK_R, 32'd680);
        push_cmd(CH_TRI_ON, 32'd690);
        push_cmd(CH_TRI_OFF, 32'd700);
        push_cmd(CH_TRI_ON, 32'd710);
        push_cmd(CH_DIGIT0, 32'd720);
        push_cmd(CH_DIGIT9, 32'd730);
        push_cmd(CH_STOP, 32'd740);
        push_cmd(8'hFF, 32'd750);
        push_cmd(CH_FWD, 32'd2000);
        push_cmd(CH_NONE, 32'd3000);
        push_cmd(CH_NONE, 32'd3001);
        push_cmd(CH_LVMAX, 32'hFFFF_FF00);
        push_cmd(CH_FWD, 32'hFFFF_FFFF);
        push_cmd(CH_NONE, 32'h0000_0100);
        push_cmd(CH_NONE, 32'h0000_0400);
        drain();

        set_config(1023, 1, 0);
        run_phase(0, 0, 80);
        set_config(0, 255, 65535);
        run_phase(62, 0, 100);
        set_config($urandom_range(1023), $urandom_range(1, 255), $urandom_range(3000));
        run_phase(0, 62, 100);
        set_config(1023, 0, $urandom_range(200));
        run_phase(18, 18, 100);
        set_config($urandom_range(1023), $urandom_range(1, 255), $urandom_range(3000));
        run_phase(0, 0, 120);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
